[hdl/u8dec_pkg.sv]
// ----------------------------------------------------------------------------
// u8dec_pkg: shared definitions for the UTF-8 code point decoder
// Status codes, field widths and the byte class constants used by the
// decoder and its stream interfaces.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    // Field widths.
    localparam int ByteWidth   = 8;
    localparam int CpWidth     = 21;
    localparam int BackWidth   = 2;
    localparam int RemWidth    = 2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRUNC   = 3'd1,
        ST_BADCONT = 3'd2,
        ST_SURR    = 3'd3,
        ST_BIGLEAD = 3'd4,
        ST_RANGE   = 3'd5
    } status_t;

    // Byte classes and masks.
    localparam logic [ByteWidth-1:0] ContMask    = 8'hC0;
    localparam logic [ByteWidth-1:0] ContTag     = 8'h80;
    localparam logic [ByteWidth-1:0] AsciiLimit  = 8'h80;
    localparam logic [ByteWidth-1:0] Lead2Max    = 8'hDF;
    localparam logic [ByteWidth-1:0] Lead3Max    = 8'hEF;
    localparam logic [ByteWidth-1:0] Lead4Max    = 8'hF4;

    // Code point limits.
    localparam logic [CpWidth-1:0] SurrLow   = 21'h00D800;
    localparam logic [CpWidth-1:0] SurrHigh  = 21'h00DFFF;
    localparam logic [CpWidth-1:0] CpMax     = 21'h10FFFF;

endpackage

[hdl/u8dec_in_if.sv]
// ----------------------------------------------------------------------------
// u8dec_in_if: byte stream channel
// Carries one byte or an end-of-stream mark per request.
// ----------------------------------------------------------------------------
interface u8dec_in_if;

    logic                              valid;
    logic                              ready;
    logic [u8dec_pkg::ByteWidth-1:0]   byte_value;
    logic                              end_of_stream;

    modport source (output valid, output byte_value, output end_of_stream, input ready);
    modport sink   (input valid, input byte_value, input end_of_stream, output ready);

endinterface

[hdl/u8dec_out_if.sv]
// ----------------------------------------------------------------------------
// u8dec_out_if: decoded code point channel
// Carries one code point or an error report per request.
// ----------------------------------------------------------------------------
interface u8dec_out_if;

    logic                              valid;
    logic                              ready;
    logic [u8dec_pkg::CpWidth-1:0]     code_point;
    u8dec_pkg::status_t                status;
    logic [u8dec_pkg::BackWidth-1:0]   column_back;

    modport source (output valid, output code_point, output status, output column_back,
                    input ready);
    modport sink   (input valid, input code_point, input status, input column_back,
                    output ready);

endinterface

[hdl/utf8_code_point_decoder_top.sv]
// A result is registered into the output register when the byte that completes it
// (or the error byte) is accepted.
// Throughput: one byte per cycle while the output register is empty or being drained; the decode
// path is a single pass from the sequence state and the byte into the output register.
// Reset clears the sequence state to idle and empties the output register.
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_top: UTF-8 byte stream to code point decoder
// Decodes one byte per request, accumulates multi-byte sequences and
// reports truncation, bad continuation, oversized lead, surrogate and range errors.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    u8dec_in_if.sink      stream,
    u8dec_out_if.source   points
);

    // Sequence state.
    logic [u8dec_pkg::RemWidth-1:0]  rem_reg, rem_next;
    logic [u8dec_pkg::RemWidth-1:0]  len_reg, len_next;
    logic [u8dec_pkg::CpWidth-1:0]   acc_reg, acc_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic [u8dec_pkg::CpWidth-1:0]   out_cp_reg;
    u8dec_pkg::status_t              out_status_reg;
    logic [u8dec_pkg::BackWidth-1:0] out_back_reg;

    // Decode results for the byte at the input.
    logic                            emit;
    logic [u8dec_pkg::CpWidth-1:0]   emit_cp;
    u8dec_pkg::status_t              emit_status;
    logic [u8dec_pkg::BackWidth-1:0] emit_back;
    logic [u8dec_pkg::RemWidth-1:0]  rem_dec;
    logic [u8dec_pkg::CpWidth-1:0]   cont_bits;
    logic [u8dec_pkg::CpWidth-1:0]   acc_full;
    logic                            accept;
    logic                            out_fire;

    logic [u8dec_pkg::ByteWidth-1:0] b;
    assign b = stream.byte_value;

    // A new byte is taken whenever the output register is empty or being drained.
    assign stream.ready = !out_valid_reg || points.ready;
    assign accept       = stream.valid && stream.ready;
    assign out_fire     = out_valid_reg && points.ready;

    // Continuation payload placed at the slot for the remaining count.
    assign rem_dec = rem_reg - 2'd1;
    always_comb
    begin
        case (rem_dec)
            2'd0:    cont_bits = {15'd0, b[5:0]};
            2'd1:    cont_bits = {9'd0, b[5:0], 6'd0};
            2'd2:    cont_bits = {3'd0, b[5:0], 12'd0};
            default: cont_bits = '0;
        endcase
    end
    assign acc_full = acc_reg | cont_bits;

    // Decode of one item against the sequence state.
    always_comb
    begin
        rem_next    = rem_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        emit        = 1'b0;
        emit_cp     = '0;
        emit_status = u8dec_pkg::ST_OK;
        emit_back   = '0;
        if (accept)
        begin
            if (rem_reg == 2'd0)
            begin
                if (stream.end_of_stream)
                begin
                    emit = 1'b0;
                end
                else if (b < u8dec_pkg::AsciiLimit)
                begin
                    emit    = 1'b1;
                    emit_cp = {13'd0, b};
                end
                else if (b <= u8dec_pkg::Lead2Max)
                begin
                    acc_next = {10'd0, b[4:0], 6'd0};
                    rem_next = 2'd1;
                    len_next = 2'd1;
                end
                else if (b <= u8dec_pkg::Lead3Max)
                begin
                    acc_next = {5'd0, b[3:0], 12'd0};
                    rem_next = 2'd2;
                    len_next = 2'd2;
                end
                else if (b <= u8dec_pkg::Lead4Max)
                begin
                    acc_next = {b[2:0], 18'd0};
                    rem_next = 2'd3;
                    len_next = 2'd3;
                end
                else
                begin
                    emit        = 1'b1;
                    emit_status = u8dec_pkg::ST_BIGLEAD;
                    emit_back   = 2'd1;
                end
            end
            else if (stream.end_of_stream)
            begin
                rem_next    = '0;
                len_next    = '0;
                acc_next    = '0;
                emit        = 1'b1;
                emit_status = u8dec_pkg::ST_TRUNC;
            end
            else if ((b & u8dec_pkg::ContMask) != u8dec_pkg::ContTag)
            begin
                rem_next    = '0;
                len_next    = '0;
                acc_next    = '0;
                emit        = 1'b1;
                emit_status = u8dec_pkg::ST_BADCONT;
                emit_back   = 2'd1;
            end
            else if (rem_dec != 2'd0)
            begin
                rem_next = rem_dec;
                acc_next = acc_full;
            end
            else
            begin
                // Sequence complete: range checks, then back to idle.
                rem_next = '0;
                len_next = '0;
                acc_next = '0;
                emit     = 1'b1;
                if (len_reg == 2'd2 && acc_full >= u8dec_pkg::SurrLow
                    && acc_full <= u8dec_pkg::SurrHigh)
                begin
                    emit_status = u8dec_pkg::ST_SURR;
                    emit_back   = 2'd3;
                end
                else if (len_reg == 2'd3 && acc_full > u8dec_pkg::CpMax)
                begin
                    emit_status = u8dec_pkg::ST_RANGE;
                    emit_back   = 2'd3;
                end
                else
                begin
                    emit_cp = acc_full;
                end
            end
        end
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            len_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            len_reg       <= len_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_cp_reg     <= emit_cp;
            out_status_reg <= emit_status;
            out_back_reg   <= emit_back;
        end
    end

    assign points.valid       = out_valid_reg;
    assign points.code_point  = out_cp_reg;
    assign points.status      = out_status_reg;
    assign points.column_back = out_back_reg;

    // An error result never carries a code point.
    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != u8dec_pkg::ST_OK) |-> (out_cp_reg == '0))
        else $error("error result with nonzero code point");

    // A good result never carries a back-off.
    a_ok_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == u8dec_pkg::ST_OK) |-> (out_back_reg == '0))
        else $error("ok result with nonzero column back-off");

    // Idle remaining count and idle sequence length go together.
    a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 2'd0) == (len_reg == 2'd0))
        else $error("sequence length out of step with remaining count");

    // End of stream inside a sequence yields a truncation report next cycle.
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stream.end_of_stream && rem_reg != 2'd0)
        |=> (out_valid_reg && out_status_reg == u8dec_pkg::ST_TRUNC && rem_reg == 2'd0))
        else $error("missing truncation report");

endmodule
